@@ rtl/assert_macros.svh @@
// Assertion macros for the top level of the IMU sample conditioner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/isc_pkg.sv @@
// Shared types and constants for the IMU sample conditioner.
package isc_pkg;

   // Fixed field and state widths
   localparam int SAMPLE_W   = 16;
   localparam int GYRO_W     = 28;
   localparam int ACC_W      = 32;
   localparam int RATE_W     = 19;
   localparam int GAIN_W     = 16;
   localparam int MASK_W     = 3;
   localparam int AXES       = 3;
   localparam int AXIS_W     = 2;
   localparam int DIFF_W     = ACC_W + 1;
   localparam int PROD_W     = DIFF_W + GAIN_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 3;

   // Rate scaling: counts / 65.5 is done as 2 * counts / 131
   localparam int RATE_DIV      = 131;
   localparam int RATE_DIV_HALF = 65;
   localparam int DIV_STEPS     = 8;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_GAIN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_GAIN  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_GAIN = 3'd6;

   // Register reset values
   localparam logic [GAIN_W-1:0] FAST_GAIN_RST  = 16'd23673;
   localparam logic [GAIN_W-1:0] SLOW_GAIN_RST  = 16'd10394;
   localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST = 16'd3874;

   // Axis codes
   localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SUB,
      ST_MUL,
      ST_ACC,
      ST_EMIT
   } isc_state_type;

   // Filter being updated by the shared unit
   typedef enum logic [1:0] {
      FILT_SLOW,
      FILT_FAST,
      FILT_ACCEL
   } isc_filter_type;

   // Step controls for the shared multiply/update unit
   typedef struct packed {
      logic diff_en;
      logic prod_en;
      logic wide;
   } isc_mac_ctrl_type;

endpackage

@@ rtl/isc_div131.sv @@
// Iterative divider by the rate constant, STEPS quotient bits per cycle.
module isc_div131 #(
   parameter int DVD_W = 34,
   parameter int STEPS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   output logic [DVD_W-1:0] quotient,
   output logic             done
);

   localparam int CYCLES = (DVD_W + STEPS - 1) / STEPS;
   localparam int PAD_W  = CYCLES * STEPS;
   localparam int CNT_W  = $clog2(CYCLES + 1);
   localparam int REM_W  = $clog2(isc_pkg::RATE_DIV);
   localparam logic [REM_W:0] DIVISOR = (REM_W + 1)'(isc_pkg::RATE_DIV);

   logic [PAD_W-1:0] num_ff, num_in;
   logic [PAD_W-1:0] quo_ff, quo_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [REM_W-1:0] step_rem;
   logic [STEPS-1:0] step_q;

   // Run STEPS restoring steps on the top dividend bits
   always_comb begin
      logic [REM_W:0]   trial;
      logic [REM_W-1:0] r;
      r      = rem_ff;
      step_q = '0;
      for (int i = 0; i < STEPS; i++) begin
         trial = {r, num_ff[PAD_W-1-i]};
         if (trial >= DIVISOR) begin
            trial             = trial - DIVISOR;
            step_q[STEPS-1-i] = 1'b1;
         end
         r = trial[REM_W-1:0];
      end
      step_rem = r;
   end

   // Load on start, advance while busy
   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = PAD_W'(dividend);
         quo_in  = '0;
         rem_in  = '0;
         cnt_in  = CNT_W'(CYCLES);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << STEPS;
         quo_in = (quo_ff << STEPS) | PAD_W'(step_q);
         rem_in = step_rem;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient = quo_ff[DVD_W-1:0];
   assign done     = done_ff;

endmodule

@@ rtl/isc_mac.sv @@
// Shared filter update unit: difference, gain multiply, rounded add with saturation.
module isc_mac #(
   parameter int COEF_BITS = 16
) (
   input  logic                                clock,
   input  isc_pkg::isc_mac_ctrl_type           ctrl,
   input  logic        [isc_pkg::GAIN_W-1:0]   gain,
   input  logic signed [isc_pkg::ACC_W-1:0]    x_val,
   input  logic signed [isc_pkg::ACC_W-1:0]    s_val,
   output logic signed [isc_pkg::ACC_W-1:0]    s_upd
);

   localparam int DIFF_W = isc_pkg::DIFF_W;
   localparam int PROD_W = isc_pkg::PROD_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam logic signed [PROD_W-1:0] ROUND = PROD_W'(longint'(1) << (COEF_BITS - 1));
   localparam logic signed [SUM_W-1:0] GYRO_HI =
      SUM_W'((longint'(1) << (isc_pkg::GYRO_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] ACC_HI =
      SUM_W'((longint'(1) << (isc_pkg::ACC_W - 1)) - 1);

   logic signed [DIFF_W-1:0]          diff_ff, diff_in;
   logic signed [PROD_W-1:0]          prod_ff, prod_in;
   logic signed [isc_pkg::GAIN_W:0]   k_s;
   logic signed [PROD_W-1:0]          mult;
   logic signed [PROD_W-1:0]          step;
   logic signed [SUM_W-1:0]           sum;
   logic signed [SUM_W-1:0]           hi;
   logic signed [SUM_W-1:0]           lo;

   // Form the filter error, then the rounded gain product
   always_comb begin
      k_s     = $signed({1'b0, gain});
      mult    = k_s * diff_ff;
      diff_in = ctrl.diff_en ? (DIFF_W'(x_val) - DIFF_W'(s_val)) : diff_ff;
      prod_in = ctrl.prod_en ? (mult + ROUND) : prod_ff;
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      prod_ff <= prod_in;
   end

   // Add the scaled error to the state and clamp to the state width
   always_comb begin
      step = prod_ff >>> COEF_BITS;
      sum  = SUM_W'(s_val) + SUM_W'(step);
      hi   = ctrl.wide ? ACC_HI : GYRO_HI;
      lo   = -hi - SUM_W'(1);
      if (sum > hi) begin
         s_upd = isc_pkg::ACC_W'(hi);
      end else if (sum < lo) begin
         s_upd = isc_pkg::ACC_W'(lo);
      end else begin
         s_upd = isc_pkg::ACC_W'(sum);
      end
   end

endmodule

@@ rtl/isc_fmt.sv @@
// Result formatting: round filter states, apply axis inversion, saturate.
module isc_fmt #(
   parameter int STATE_FRAC_BITS = 16
) (
   input  logic signed [isc_pkg::GYRO_W-1:0]   fast_st,
   input  logic signed [isc_pkg::GYRO_W-1:0]   slow_st,
   input  logic signed [isc_pkg::ACC_W-1:0]    acc_st,
   input  logic signed [isc_pkg::SAMPLE_W-1:0] held_raw,
   input  logic                                negate,
   input  logic                                primed,
   output logic signed [isc_pkg::RATE_W-1:0]   rate_fast,
   output logic signed [isc_pkg::RATE_W-1:0]   rate_slow,
   output logic signed [isc_pkg::SAMPLE_W-1:0] accel_raw,
   output logic signed [isc_pkg::SAMPLE_W-1:0] accel_smooth
);

   localparam int RSH = STATE_FRAC_BITS - 8;
   localparam int RW  = isc_pkg::GYRO_W + 2;
   localparam int AW  = isc_pkg::ACC_W + 2;
   localparam int SW  = isc_pkg::SAMPLE_W + 1;
   localparam logic signed [RW-1:0] R_RND = RW'((longint'(1) << RSH) >> 1);
   localparam logic signed [AW-1:0] A_RND = AW'((longint'(1) << STATE_FRAC_BITS) >> 1);
   localparam logic signed [RW-1:0] R_MAX = RW'((longint'(1) << (isc_pkg::RATE_W - 1)) - 1);
   localparam logic signed [RW-1:0] R_MIN = -R_MAX - RW'(1);
   localparam logic signed [AW-1:0] A_MAX = AW'((longint'(1) << (isc_pkg::SAMPLE_W - 1)) - 1);
   localparam logic signed [AW-1:0] A_MIN = -A_MAX - AW'(1);
   localparam logic signed [SW-1:0] S_MAX = SW'((longint'(1) << (isc_pkg::SAMPLE_W - 1)) - 1);
   localparam logic signed [SW-1:0] S_MIN = -S_MAX - SW'(1);

   // Round a gyro state to deg/s * 256, invert and clamp
   function automatic logic signed [isc_pkg::RATE_W-1:0] round_rate(
      input logic signed [isc_pkg::GYRO_W-1:0] st,
      input logic                              neg
   );
      logic signed [RW-1:0] v;
      v = (RW'(st) + R_RND) >>> RSH;
      if (neg) begin
         v = -v;
      end
      if (v > R_MAX) begin
         v = R_MAX;
      end else if (v < R_MIN) begin
         v = R_MIN;
      end
      return v[isc_pkg::RATE_W-1:0];
   endfunction

   // Accel state to g * 4096; report zero before the first good sample
   always_comb begin
      logic signed [AW-1:0] a;
      logic signed [SW-1:0] r;
      rate_fast = round_rate(fast_st, negate);
      rate_slow = round_rate(slow_st, negate);

      a = (AW'(acc_st) + A_RND) >>> STATE_FRAC_BITS;
      if (!primed) begin
         a = '0;
      end
      if (negate) begin
         a = -a;
      end
      if (a > A_MAX) begin
         a = A_MAX;
      end else if (a < A_MIN) begin
         a = A_MIN;
      end
      accel_smooth = a[isc_pkg::SAMPLE_W-1:0];

      r = SW'(held_raw);
      if (negate) begin
         r = -r;
      end
      if (r > S_MAX) begin
         r = S_MAX;
      end else if (r < S_MIN) begin
         r = S_MIN;
      end
      accel_raw = r[isc_pkg::SAMPLE_W-1:0];
   end

endmodule

@@ rtl/imu_sample_conditioner_unit.sv @@
// Top level of the IMU sample conditioner: sequencer, filter state and stream ports.
//
//   channel   direction  payload
//   req_      in         tdata: gyro x,y,z, accel x,y,z; tuser: read_ok
//   rsp_      out        tdata: rate_fast, rate_slow, accel_raw, accel_smooth;
//                        tuser: axis, valid_res; tlast: last (z result)
//   csr_      in         write enable, register index, write data
//
// A good sample runs, per axis, the constant divider at 8 quotient bits a cycle,
// then the shared multiplier makes three passes of difference, product and update.
// A failed read skips the divider and the filters. Reset is synchronous and clears
// the filter state, but accel z starts at one g.
// One result register parts the output; a stalled rsp_tready holds the sequencer
// at the next result, and no request is taken until all three results are loaded.
`include "assert_macros.svh"

module imu_sample_conditioner_unit #(
   parameter int COEF_BITS       = 16,
   parameter int STATE_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z (16 bits each)
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [isc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // request: read_ok
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rate_fast[18:0], rate_slow[37:19], accel_raw[53:38], accel_smooth[69:54], zero
   output logic [isc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // axis[1:0], valid_res[2]
   output logic [isc_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [isc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [isc_pkg::GAIN_W-1:0]          csr_wdata
);

   localparam int SW    = isc_pkg::SAMPLE_W;
   localparam int GW    = isc_pkg::GYRO_W;
   localparam int AWD   = isc_pkg::ACC_W;
   localparam int DIV_W = STATE_FRAC_BITS + 18;
   localparam int QW    = (DIV_W > GW + 1) ? DIV_W : GW + 1;
   localparam int AXW   = (SW + STATE_FRAC_BITS > AWD + 1) ? SW + STATE_FRAC_BITS : AWD + 1;
   localparam logic signed [QW-1:0]  Q_LIM    = QW'(longint'(1) << (GW - 1));
   localparam logic signed [GW-1:0]  GYRO_MAX = GW'((longint'(1) << (GW - 1)) - 1);
   localparam logic signed [GW-1:0]  GYRO_MIN = -GYRO_MAX - GW'(1);
   localparam logic signed [AXW-1:0] AX_MAX   = AXW'((longint'(1) << (AWD - 1)) - 1);
   localparam logic signed [AXW-1:0] AX_MIN   = -AX_MAX - AXW'(1);
   localparam longint ONE_G_L = longint'(4096) * (longint'(1) << STATE_FRAC_BITS);
   localparam logic signed [AWD-1:0] ACC_ONE_G =
      (ONE_G_L > 64'sd2147483647) ? 32'sh7FFF_FFFF : AWD'(ONE_G_L);

   // Configuration registers
   logic signed [SW-1:0]                offset_ff [isc_pkg::AXES];
   logic        [isc_pkg::MASK_W-1:0]   invert_ff;
   logic        [isc_pkg::GAIN_W-1:0]   fast_gain_ff;
   logic        [isc_pkg::GAIN_W-1:0]   slow_gain_ff;
   logic        [isc_pkg::GAIN_W-1:0]   accel_gain_ff;

   // Captured sample and filter state
   logic signed [SW-1:0]  gyro_ff   [isc_pkg::AXES];
   logic signed [SW-1:0]  accel_ff  [isc_pkg::AXES];
   logic signed [GW-1:0]  fast_st_ff [isc_pkg::AXES];
   logic signed [GW-1:0]  slow_st_ff [isc_pkg::AXES];
   logic signed [AWD-1:0] acc_st_ff  [isc_pkg::AXES];
   logic signed [SW-1:0]  held_ff    [isc_pkg::AXES];
   logic                  ok_ff;
   logic                  primed_ff;

   // Sequencer
   isc_pkg::isc_state_type          state_ff, state_in;
   isc_pkg::isc_filter_type         filt_ff, filt_in;
   logic [isc_pkg::AXIS_W-1:0]      axis_ff, axis_in;
   logic signed [GW-1:0]            xg_ff, xg_in;
   isc_pkg::isc_mac_ctrl_type       mac_ctrl;
   logic                            req_fire;
   logic                            out_free;
   logic                            div_start;
   logic                            div_done;
   logic                            xg_we;
   logic                            st_we;
   logic                            held_we;
   logic                            emit_fire;

   // Datapath
   logic signed [SW:0]              gdiff;
   logic        [SW:0]              gmag;
   logic        [DIV_W-1:0]         dividend;
   logic        [DIV_W-1:0]         quotient;
   logic signed [QW-1:0]            q_w;
   logic signed [AXW-1:0]           ax_wide;
   logic signed [AWD-1:0]           ax_val;
   logic signed [AWD-1:0]           mac_x;
   logic signed [AWD-1:0]           mac_s;
   logic        [isc_pkg::GAIN_W-1:0] mac_gain;
   logic signed [AWD-1:0]           s_upd;
   logic signed [isc_pkg::RATE_W-1:0] fmt_rf;
   logic signed [isc_pkg::RATE_W-1:0] fmt_rs;
   logic signed [SW-1:0]            fmt_ar;
   logic signed [SW-1:0]            fmt_as;

   // Result register
   logic                              rsp_valid_ff;
   logic [isc_pkg::RSP_DATA_W-1:0]    rsp_data_ff;
   logic [isc_pkg::RSP_USER_W-1:0]    rsp_user_ff;
   logic                              rsp_last_ff;

   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Take configuration writes; ignore indexes past the register list
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < isc_pkg::AXES; i++) begin
            offset_ff[i] <= '0;
         end
         invert_ff     <= '0;
         fast_gain_ff  <= isc_pkg::FAST_GAIN_RST;
         slow_gain_ff  <= isc_pkg::SLOW_GAIN_RST;
         accel_gain_ff <= isc_pkg::ACCEL_GAIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            isc_pkg::CSR_OFFSET_X:   offset_ff[0]  <= $signed(csr_wdata[SW-1:0]);
            isc_pkg::CSR_OFFSET_Y:   offset_ff[1]  <= $signed(csr_wdata[SW-1:0]);
            isc_pkg::CSR_OFFSET_Z:   offset_ff[2]  <= $signed(csr_wdata[SW-1:0]);
            isc_pkg::CSR_INVERT:     invert_ff     <= csr_wdata[isc_pkg::MASK_W-1:0];
            isc_pkg::CSR_FAST_GAIN:  fast_gain_ff  <= csr_wdata;
            isc_pkg::CSR_SLOW_GAIN:  slow_gain_ff  <= csr_wdata;
            isc_pkg::CSR_ACCEL_GAIN: accel_gain_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Next state of the sequencer
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      filt_in  = filt_ff;
      case (state_ff)
         isc_pkg::ST_IDLE: begin
            if (req_fire) begin
               axis_in  = isc_pkg::AXIS_X;
               state_in = req_tuser ? isc_pkg::ST_DIV_START : isc_pkg::ST_EMIT;
            end
         end
         isc_pkg::ST_DIV_START: begin
            state_in = isc_pkg::ST_DIV_WAIT;
         end
         isc_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               filt_in  = isc_pkg::FILT_SLOW;
               state_in = isc_pkg::ST_SUB;
            end
         end
         isc_pkg::ST_SUB: begin
            state_in = isc_pkg::ST_MUL;
         end
         isc_pkg::ST_MUL: begin
            state_in = isc_pkg::ST_ACC;
         end
         isc_pkg::ST_ACC: begin
            case (filt_ff)
               isc_pkg::FILT_SLOW: begin
                  filt_in  = isc_pkg::FILT_FAST;
                  state_in = isc_pkg::ST_SUB;
               end
               isc_pkg::FILT_FAST: begin
                  filt_in  = isc_pkg::FILT_ACCEL;
                  state_in = isc_pkg::ST_SUB;
               end
               default: begin
                  state_in = isc_pkg::ST_EMIT;
               end
            endcase
         end
         isc_pkg::ST_EMIT: begin
            if (out_free) begin
               if (axis_ff == isc_pkg::AXIS_Z) begin
                  state_in = isc_pkg::ST_IDLE;
               end else begin
                  axis_in  = axis_ff + isc_pkg::AXIS_W'(1);
                  state_in = ok_ff ? isc_pkg::ST_DIV_START : isc_pkg::ST_EMIT;
               end
            end
         end
         default: begin
            state_in = isc_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready       = 1'b0;
      div_start        = 1'b0;
      held_we          = 1'b0;
      xg_we            = 1'b0;
      st_we            = 1'b0;
      emit_fire        = 1'b0;
      mac_ctrl.diff_en = 1'b0;
      mac_ctrl.prod_en = 1'b0;
      mac_ctrl.wide    = (filt_ff == isc_pkg::FILT_ACCEL);
      case (state_ff)
         isc_pkg::ST_IDLE:      req_tready = 1'b1;
         isc_pkg::ST_DIV_START: begin
            div_start = 1'b1;
            held_we   = 1'b1;
         end
         isc_pkg::ST_DIV_WAIT:  xg_we = div_done;
         isc_pkg::ST_SUB:       mac_ctrl.diff_en = 1'b1;
         isc_pkg::ST_MUL:       mac_ctrl.prod_en = 1'b1;
         isc_pkg::ST_ACC:       st_we = 1'b1;
         isc_pkg::ST_EMIT:      emit_fire = out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= isc_pkg::ST_IDLE;
         filt_ff  <= isc_pkg::FILT_SLOW;
         axis_ff  <= isc_pkg::AXIS_X;
      end else begin
         state_ff <= state_in;
         filt_ff  <= filt_in;
         axis_ff  <= axis_in;
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < isc_pkg::AXES; i++) begin
            gyro_ff[i]  <= $signed(req_tdata[i*SW +: SW]);
            accel_ff[i] <= $signed(req_tdata[(isc_pkg::AXES + i)*SW +: SW]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ok_ff     <= 1'b0;
         primed_ff <= 1'b0;
      end else if (req_fire) begin
         ok_ff <= req_tuser;
         if (req_tuser) begin
            primed_ff <= 1'b1;
         end
      end
   end

   // Gyro offset removal and magnitude for the constant divider
   always_comb begin
      gdiff    = (SW + 1)'(gyro_ff[axis_ff]) - (SW + 1)'(offset_ff[axis_ff]);
      gmag     = gdiff[SW] ? (SW + 1)'(-gdiff) : (SW + 1)'(gdiff);
      dividend = (DIV_W'(gmag) << (STATE_FRAC_BITS + 1)) + DIV_W'(isc_pkg::RATE_DIV_HALF);
   end

   isc_div131 #(
      .DVD_W (DIV_W),
      .STEPS (isc_pkg::DIV_STEPS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .quotient (quotient),
      .done     (div_done)
   );

   // Restore the sign and clamp the gyro filter input
   always_comb begin
      q_w = QW'(quotient);
      if (gdiff[SW]) begin
         xg_in = (q_w >= Q_LIM) ? GYRO_MIN : -GW'(q_w);
      end else begin
         xg_in = (q_w >= Q_LIM - QW'(1)) ? GYRO_MAX : GW'(q_w);
      end
   end

   always_ff @(posedge clock) begin
      if (xg_we) begin
         xg_ff <= xg_in;
      end
   end

   // Accel filter input, clamped to the state width
   always_comb begin
      ax_wide = AXW'(accel_ff[axis_ff]) <<< STATE_FRAC_BITS;
      if (ax_wide > AX_MAX) begin
         ax_val = AWD'(AX_MAX);
      end else if (ax_wide < AX_MIN) begin
         ax_val = AWD'(AX_MIN);
      end else begin
         ax_val = AWD'(ax_wide);
      end
   end

   // Select operands of the shared unit
   always_comb begin
      case (filt_ff)
         isc_pkg::FILT_SLOW: begin
            mac_x    = AWD'(xg_ff);
            mac_s    = AWD'(slow_st_ff[axis_ff]);
            mac_gain = slow_gain_ff;
         end
         isc_pkg::FILT_FAST: begin
            mac_x    = AWD'(xg_ff);
            mac_s    = AWD'(fast_st_ff[axis_ff]);
            mac_gain = fast_gain_ff;
         end
         default: begin
            mac_x    = ax_val;
            mac_s    = acc_st_ff[axis_ff];
            mac_gain = accel_gain_ff;
         end
      endcase
   end

   isc_mac #(
      .COEF_BITS (COEF_BITS)
   ) u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .gain  (mac_gain),
      .x_val (mac_x),
      .s_val (mac_s),
      .s_upd (s_upd)
   );

   // Write back filter state and the raw accel sample
   always_ff @(posedge clock) begin
      if (reset) begin
         // accel z starts at one g
         for (int i = 0; i < isc_pkg::AXES; i++) begin
            fast_st_ff[i] <= '0;
            slow_st_ff[i] <= '0;
            acc_st_ff[i]  <= (i == int'(isc_pkg::AXIS_Z)) ? ACC_ONE_G : '0;
            held_ff[i]    <= '0;
         end
      end else begin
         if (held_we) begin
            held_ff[axis_ff] <= accel_ff[axis_ff];
         end
         if (st_we) begin
            case (filt_ff)
               isc_pkg::FILT_SLOW: slow_st_ff[axis_ff] <= GW'(s_upd);
               isc_pkg::FILT_FAST: fast_st_ff[axis_ff] <= GW'(s_upd);
               default:            acc_st_ff[axis_ff]  <= s_upd;
            endcase
         end
      end
   end

   isc_fmt #(
      .STATE_FRAC_BITS (STATE_FRAC_BITS)
   ) u_fmt (
      .fast_st      (fast_st_ff[axis_ff]),
      .slow_st      (slow_st_ff[axis_ff]),
      .acc_st       (acc_st_ff[axis_ff]),
      .held_raw     (held_ff[axis_ff]),
      .negate       (invert_ff[axis_ff]),
      .primed       (primed_ff),
      .rate_fast    (fmt_rf),
      .rate_slow    (fmt_rs),
      .accel_raw    (fmt_ar),
      .accel_smooth (fmt_as)
   );

   // Load the result register; drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_data_ff <= {2'b00, fmt_as, fmt_ar, fmt_rs, fmt_rf};
         rsp_user_ff <= {ok_ff, axis_ff};
         rsp_last_ff <= (axis_ff == isc_pkg::AXIS_Z);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_tready)
   `ASSERT_IMPLIES(a_div_done_awaited, clock, reset, div_done, state_ff == isc_pkg::ST_DIV_WAIT)
   `ASSERT_NEXT(a_free_after_z, clock, reset, emit_fire && axis_ff == isc_pkg::AXIS_Z, req_tready)

endmodule
